>>> rtl/core/tcw_pkg.sv
// Shared constants, types and command/status structs for the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  // Internal widths follow from the geometry.
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CUR_W  = $clog2(CELLS + COLUMNS + 1);
  localparam int unsigned COL_W  = $clog2(COLUMNS);

  // Port field widths are fixed by the interface.
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned SCNT_W = 2;
  localparam int unsigned CELL_W = 2 * CHAR_W;

  // Blank cell: space, light grey on black.
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

  // Character codes with special meaning.
  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  // Classification of an incoming word.
  typedef enum logic [2:0] {
    K_NOP,
    K_PRINT,
    K_CTRL,
    K_CLEAR,
    K_READ
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // latch the incoming word
    logic adjust;     // apply line feed or carriage return to the cursor
    logic home;       // cursor to zero
    logic ctr_clr;    // clear the sweep counter
    logic fill;       // write a blank cell at the sweep counter
    logic copy;       // one step of the scroll copy
    logic copy_done;  // scroll finished: cursor up one row, count it
    logic store;      // store the latched character at the cursor
    logic rd_issue;   // read the cell named by the incoming word
    logic out_load;   // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;        // class of the incoming word
    logic  store_item;  // latched word is a printable character
    logic  cur_past;    // cursor past the last cell
    logic  fill_end;    // sweep counter at the last cell
    logic  copy_end;    // scroll copy at its last step
    logic  out_free;    // result register can take a new word
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/text_console_writer_unit.sv
// Top level of the text console writer.
//
// Keeps an 80x25 screen of 16-bit cells (attribute byte high, character byte low) in a
// single-port-write, single-port-read memory, plus a linear cursor. One word is handled
// at a time and each gives exactly one result word. Every one-row scroll copies the screen
// up one row, one cell per cycle through the memory's single read and write port, then
// the cursor test runs again. A clear runs the blanking sweep, which writes one cell per
// cycle. After reset the same sweep runs, and no input word is taken until it is done.
// The result register lets the next word be taken while a result is still stalled.
`default_nettype none

module text_console_writer_unit import tcw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [CHAR_W-1:0] attribute_i,
  input  wire logic [IDX_W-1:0]  cell_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [POS_W-1:0]       cursor_position_o,
  output logic [CHAR_W-1:0]      read_char_o,
  output logic [CHAR_W-1:0]      read_attr_o,
  output logic [SCNT_W-1:0]      scroll_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  tcw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .action_i          (action_i),
    .char_code_i       (char_code_i),
    .attribute_i       (attribute_i),
    .cell_index_i      (cell_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_position_o (cursor_position_o),
    .read_char_o       (read_char_o),
    .read_attr_o       (read_attr_o),
    .scroll_count_o    (scroll_count_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/tcw_ctrl.sv
// Controller state machine of the text console writer.
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_CHECK  = 6'b000100,
    S_SCROLL = 6'b001000,
    S_READ   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   clr_res_q, clr_res_d;

  // Only the idle state takes a new word.
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    clr_res_d = clr_res_q;
    cmd_o     = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.fill = 1'b1;
        if (stat_i.fill_end) begin
          cmd_o.ctr_clr = 1'b1;
          clr_res_d     = 1'b0;
          state_d       = clr_res_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (stat_i.kind)
            K_PRINT, K_CTRL: begin
              cmd_o.adjust = 1'b1;
              state_d      = S_CHECK;
            end
            K_CLEAR: begin
              cmd_o.home    = 1'b1;
              cmd_o.ctr_clr = 1'b1;
              clr_res_d     = 1'b1;
              state_d       = S_CLEAR;
            end
            K_READ: begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_READ;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (stat_i.cur_past) begin
          cmd_o.ctr_clr = 1'b1;
          state_d       = S_SCROLL;
        end else begin
          cmd_o.store = stat_i.store_item;
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCROLL: begin
        cmd_o.copy = 1'b1;
        if (stat_i.copy_end) begin
          cmd_o.copy_done = 1'b1;
          cmd_o.ctr_clr   = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_READ, S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // State registers; reset starts the blanking sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_res_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_res_q <= clr_res_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tcw_datapath.sv
// Datapath of the text console writer: screen memory, cursor, sweep counter, result register.
`default_nettype none

module tcw_datapath import tcw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_stat_t               stat_o,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [CHAR_W-1:0] attribute_i,
  input  wire logic [IDX_W-1:0]  cell_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [POS_W-1:0]       cursor_position_o,
  output logic [CHAR_W-1:0]      read_char_o,
  output logic [CHAR_W-1:0]      read_attr_o,
  output logic [SCNT_W-1:0]      scroll_count_o
);

  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  logic [CUR_W-1:0]  cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] ctr_q, ctr_d;
  logic [SCNT_W-1:0] scnt_q, scnt_d;
  logic              store_q, rd_hit_q, out_valid_q;
  logic [CHAR_W-1:0] code_q, attr_q;

  logic [POS_W-1:0]  out_pos_q;
  logic [CHAR_W-1:0] out_char_q, out_attr_q;
  logic [SCNT_W-1:0] out_scnt_q;

  kind_e             kind;
  logic              idx_hit, copy_rd, copy_wr;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [CELL_W-1:0] wr_data;

  // Classify the incoming word.
  always_comb begin
    unique case (action_i)
      ACT_WRITE: begin
        if (char_code_i == CH_NUL) begin
          kind = K_NOP;
        end else if (char_code_i == CH_LF || char_code_i == CH_CR) begin
          kind = K_CTRL;
        end else begin
          kind = K_PRINT;
        end
      end
      ACT_CLEAR: kind = K_CLEAR;
      ACT_READ:  kind = K_READ;
      ACT_NONE:  kind = K_NOP;
      default:   kind = K_NOP;
    endcase
  end

  assign idx_hit = (cell_index_i < IDX_W'(CELLS));

  // Scroll copy: read one row ahead, write the cell read in the previous cycle.
  assign copy_rd = cmd_i.copy && (ctr_q < ADDR_W'(CELLS - COLUMNS));
  assign copy_wr = cmd_i.copy && (ctr_q != '0);

  // Memory port selection.
  assign rd_en   = copy_rd || (cmd_i.rd_issue && idx_hit);
  assign rd_addr = cmd_i.copy ? (ctr_q + ADDR_W'(COLUMNS)) : ADDR_W'(cell_index_i);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ctr_q;
    wr_data = BLANK_CELL;
    priority if (cmd_i.fill) begin
      wr_en = 1'b1;
    end else if (copy_wr) begin
      wr_en   = 1'b1;
      wr_addr = ctr_q - ADDR_W'(1);
      wr_data = rdata_q;
    end else if (cmd_i.store) begin
      wr_en   = 1'b1;
      wr_addr = cursor_q[ADDR_W-1:0];
      wr_data = {attr_q, code_q};
    end else begin
      wr_en = 1'b0;
    end
  end

  // Screen memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Cursor and column update.
  always_comb begin
    cursor_d = cursor_q;
    col_d    = col_q;
    priority if (cmd_i.home) begin
      cursor_d = '0;
      col_d    = '0;
    end else if (cmd_i.adjust) begin
      if (char_code_i == CH_LF) begin
        cursor_d = cursor_q + CUR_W'(COLUMNS);
      end else if (char_code_i == CH_CR) begin
        cursor_d = cursor_q - CUR_W'(col_q);
        col_d    = '0;
      end
    end else if (cmd_i.copy_done) begin
      cursor_d = cursor_q - CUR_W'(COLUMNS);
    end else if (cmd_i.store) begin
      cursor_d = cursor_q + CUR_W'(1);
      col_d    = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
    end else begin
      cursor_d = cursor_q;
    end
  end

  // Sweep counter and scroll count.
  always_comb begin
    if (cmd_i.ctr_clr) begin
      ctr_d = '0;
    end else if (cmd_i.fill || cmd_i.copy) begin
      ctr_d = ctr_q + ADDR_W'(1);
    end else begin
      ctr_d = ctr_q;
    end
    if (cmd_i.take) begin
      scnt_d = '0;
    end else if (cmd_i.copy_done) begin
      scnt_d = scnt_q + SCNT_W'(1);
    end else begin
      scnt_d = scnt_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      col_q       <= '0;
      ctr_q       <= '0;
      scnt_q      <= '0;
      store_q     <= 1'b0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      ctr_q       <= ctr_d;
      scnt_q      <= scnt_d;
      out_valid_q <= cmd_i.out_load || (out_valid_q && out_stall_i);
      if (cmd_i.take) begin
        store_q  <= (kind == K_PRINT);
        rd_hit_q <= (kind == K_READ) && idx_hit;
      end
    end
  end

  // Latched character and result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      code_q <= char_code_i;
      attr_q <= attribute_i;
    end
    if (cmd_i.out_load) begin
      out_pos_q  <= cursor_d[POS_W-1:0];
      out_char_q <= rd_hit_q ? rdata_q[CHAR_W-1:0] : '0;
      out_attr_q <= rd_hit_q ? rdata_q[CELL_W-1:CHAR_W] : '0;
      out_scnt_q <= scnt_q;
    end
  end

  // Status to the controller.
  assign stat_o.kind       = kind;
  assign stat_o.store_item = store_q;
  assign stat_o.cur_past   = (cursor_q >= CUR_W'(CELLS));
  assign stat_o.fill_end   = (ctr_q == ADDR_W'(CELLS - 1));
  assign stat_o.copy_end   = (ctr_q == ADDR_W'(CELLS - COLUMNS));
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = out_pos_q;
  assign read_char_o       = out_char_q;
  assign read_attr_o       = out_attr_q;
  assign scroll_count_o    = out_scnt_q;

endmodule

`default_nettype wire

>>> rtl/core/tcw_checker.sv
// Port-level checks of the text console writer and their binding to the top level.
`default_nettype none

module tcw_checker import tcw_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_i,
  input wire logic              out_valid_i,
  input wire logic              out_stall_i,
  input wire logic [POS_W-1:0]  cursor_position_i,
  input wire logic [SCNT_W-1:0] scroll_count_i
);

  // One word at a time: after an accept the input side stalls.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |=> in_stall_i)
    else $error("input word accepted while another is in flight");

  // The cursor never passes the pending-scroll position.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cursor_position_i <= POS_W'(CELLS)))
    else $error("cursor beyond the cell count");

  // A word that scrolled leaves the cursor on the bottom row or at the pending position.
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && scroll_count_i != '0) |->
      (cursor_position_i >= POS_W'(CELLS - COLUMNS)))
    else $error("scroll left the cursor above the bottom row");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> out_valid_i)
    else $error("result word dropped while stalled");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_i        (in_stall_o),
  .out_valid_i       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .cursor_position_i (cursor_position_o),
  .scroll_count_i    (scroll_count_o)
);

`default_nettype wire
